// ----- src/frm_pkg.sv -----
package frm_pkg;

    localparam int unsigned DATA_BITS  = 32;
    localparam int unsigned WIN_BITS   = 16;
    localparam int unsigned ADDR_BITS  = 3;
    localparam int unsigned SCALE_BITS = 18;
    localparam int unsigned NUM_BITS   = 50;
    localparam int unsigned DIV_STEPS  = 32;
    localparam int unsigned CNT_BITS   = 6;

    localparam logic [SCALE_BITS-1:0] MEAN_SCALE = 18'd1000;
    localparam logic [SCALE_BITS-1:0] RATE_SCALE = 18'd256000;

    localparam logic [WIN_BITS-1:0] AVERAGE_WINDOW_RESET = 16'd20;
    localparam logic [WIN_BITS-1:0] RATE_WINDOW_RESET    = 16'd1000;

    localparam logic REG_AVERAGE_WINDOW = 1'b0;
    localparam logic REG_RATE_WINDOW    = 1'b1;

    typedef struct packed {
        logic load;
        logic acc;
        logic mul;
        logic sel_rate;
        logic div_load;
        logic div_check;
        logic div_step;
        logic write_back;
        logic add_elapsed;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mean_hit;
        logic rate_hit;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ----- src/frm_cfg.sv -----
module frm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [frm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [frm_pkg::DATA_BITS-1:0]  pwdata,
    output logic [frm_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output logic [frm_pkg::WIN_BITS-1:0]   o_average_window_ms,
    output logic [frm_pkg::WIN_BITS-1:0]   o_rate_window_ms
);

    logic [frm_pkg::WIN_BITS-1:0] r_average_window;
    logic [frm_pkg::WIN_BITS-1:0] r_rate_window;
    logic                         write_en;

    assign pready   = 1'b1;
    assign write_en = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_average_window <= frm_pkg::AVERAGE_WINDOW_RESET;
            r_rate_window    <= frm_pkg::RATE_WINDOW_RESET;
        end else if (write_en) begin
            unique case (paddr[2])
                frm_pkg::REG_AVERAGE_WINDOW: r_average_window <= pwdata[frm_pkg::WIN_BITS-1:0];
                frm_pkg::REG_RATE_WINDOW:    r_rate_window    <= pwdata[frm_pkg::WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            frm_pkg::REG_AVERAGE_WINDOW: prdata = frm_pkg::DATA_BITS'(r_average_window);
            frm_pkg::REG_RATE_WINDOW:    prdata = frm_pkg::DATA_BITS'(r_rate_window);
            default:                     prdata = '0;
        endcase
    end

    assign o_average_window_ms = r_average_window;
    assign o_rate_window_ms    = r_rate_window;

endmodule

// ----- src/frm_ctrl.sv -----
module frm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  frm_pkg::t_sts i_sts,
    output frm_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_TEST,
        S_MUL,
        S_ADJ,
        S_CHK,
        S_DIV,
        S_WB,
        S_ELAP,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_sel;
    logic   r_rate_pend;

    always_comb begin
        o_cmd          = '0;
        o_cmd.sel_rate = r_sel;
        unique case (r_state)
            S_IDLE: o_cmd.load        = i_valid;
            S_ACC:  o_cmd.acc         = 1'b1;
            S_TEST: ;
            S_MUL:  o_cmd.mul         = 1'b1;
            S_ADJ:  o_cmd.div_load    = 1'b1;
            S_CHK:  o_cmd.div_check   = 1'b1;
            S_DIV:  o_cmd.div_step    = 1'b1;
            S_WB:   o_cmd.write_back  = 1'b1;
            S_ELAP: o_cmd.add_elapsed = 1'b1;
            S_OUT:  o_cmd.out_load    = i_sts.out_free;
            default: ;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 1'b0;
            r_rate_pend <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_ACC;
                S_ACC:  r_state <= S_TEST;
                S_TEST: begin
                    // mean window goes first, rate window waits its turn
                    if (i_sts.mean_hit) begin
                        r_sel       <= 1'b0;
                        r_rate_pend <= i_sts.rate_hit;
                        r_state     <= S_MUL;
                    end else if (i_sts.rate_hit) begin
                        r_sel       <= 1'b1;
                        r_rate_pend <= 1'b0;
                        r_state     <= S_MUL;
                    end else begin
                        r_state <= S_ELAP;
                    end
                end
                S_MUL:  r_state <= S_ADJ;
                S_ADJ:  r_state <= S_CHK;
                S_CHK:  r_state <= S_DIV;
                S_DIV:  if (i_sts.div_last) r_state <= S_WB;
                S_WB: begin
                    if (r_rate_pend) begin
                        r_sel       <= 1'b1;
                        r_rate_pend <= 1'b0;
                        r_state     <= S_MUL;
                    end else begin
                        r_state <= S_ELAP;
                    end
                end
                S_ELAP: r_state <= S_OUT;
                S_OUT:  if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/frm_dp.sv -----
module frm_dp #(
    parameter int STAMP_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  frm_pkg::t_cmd                 i_cmd,
    output frm_pkg::t_sts                 o_sts,
    input  logic [31:0]                   i_timestamp_ms,
    input  logic [frm_pkg::WIN_BITS-1:0]  i_average_window_ms,
    input  logic [frm_pkg::WIN_BITS-1:0]  i_rate_window_ms,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [31:0]                   o_delta_ms,
    output logic [31:0]                   o_frame_number,
    output logic [31:0]                   o_mean_frame_us,
    output logic [31:0]                   o_frames_per_second_q8,
    output logic [63:0]                   o_elapsed_us,
    output logic                          o_mean_updated,
    output logic                          o_rate_updated
);

    localparam int          DeltaBits = (STAMP_BITS < 32) ? STAMP_BITS : 32;
    localparam logic [32:0] DeltaSpan = 33'd1 << DeltaBits;
    localparam logic [31:0] DeltaMask = 32'(DeltaSpan - 33'd1);

    // window and running state
    logic [31:0] r_prev;
    logic [31:0] r_ticks;
    logic [31:0] r_mean_frames;
    logic [31:0] r_mean_sum;
    logic [31:0] r_rate_frames;
    logic [31:0] r_rate_sum;
    logic [31:0] r_mean_value;
    logic [31:0] r_rate_value;
    logic [63:0] r_elapsed;
    logic        r_mean_upd;
    logic        r_rate_upd;
    logic        r_out_valid;

    // arithmetic payload
    logic [31:0]                          r_delta;
    logic [frm_pkg::NUM_BITS-1:0]         r_num;
    logic [31:0]                          r_den;
    logic [31:0]                          r_rem;
    logic [31:0]                          r_quo;
    logic                                 r_ovf;
    logic [frm_pkg::CNT_BITS-1:0]         r_cnt;

    logic [31:0]                          n_delta;
    logic [31:0]                          n_ticks;
    logic [31:0]                          n_mean_frames;
    logic [31:0]                          n_rate_frames;
    logic [32:0]                          mean_sum_ext;
    logic [32:0]                          rate_sum_ext;
    logic [31:0]                          n_mean_sum;
    logic [31:0]                          n_rate_sum;
    logic [31:0]                          mul_a;
    logic [frm_pkg::SCALE_BITS-1:0]       mul_k;
    logic [frm_pkg::NUM_BITS-1:0]         prod;
    logic [frm_pkg::NUM_BITS-1:0]         num_adj;
    logic [32:0]                          shifted;
    logic [33:0]                          trial;
    logic                                 take;
    logic [31:0]                          quotient;
    logic [64:0]                          elapsed_ext;
    logic [63:0]                          n_elapsed;

    always_comb begin
        n_delta       = (i_timestamp_ms - r_prev) & DeltaMask;
        n_ticks       = (&r_ticks) ? r_ticks : r_ticks + 32'd1;
        n_mean_frames = (&r_mean_frames) ? r_mean_frames : r_mean_frames + 32'd1;
        n_rate_frames = (&r_rate_frames) ? r_rate_frames : r_rate_frames + 32'd1;
        mean_sum_ext  = {1'b0, r_mean_sum} + {1'b0, r_delta};
        rate_sum_ext  = {1'b0, r_rate_sum} + {1'b0, r_delta};
        n_mean_sum    = mean_sum_ext[32] ? '1 : mean_sum_ext[31:0];
        n_rate_sum    = rate_sum_ext[32] ? '1 : rate_sum_ext[31:0];

        mul_a = i_cmd.sel_rate ? r_rate_frames : r_mean_sum;
        mul_k = i_cmd.sel_rate ? frm_pkg::RATE_SCALE : frm_pkg::MEAN_SCALE;
        prod  = mul_a * mul_k;

        // round half up: add half the divisor before dividing
        num_adj = r_num + frm_pkg::NUM_BITS'(r_den >> 1);

        shifted  = {r_rem, r_quo[31]};
        trial    = {1'b0, shifted} - {2'b00, r_den};
        take     = ~trial[33];
        quotient = r_ovf ? '1 : r_quo;

        elapsed_ext = {1'b0, r_elapsed} + 65'(r_mean_value);
        n_elapsed   = elapsed_ext[64] ? '1 : elapsed_ext[63:0];
    end

    assign o_sts.mean_hit = r_mean_sum > 32'(i_average_window_ms);
    assign o_sts.rate_hit = r_rate_sum > 32'(i_rate_window_ms);
    assign o_sts.div_last = (r_cnt == frm_pkg::CNT_BITS'(1));
    assign o_sts.out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_ticks       <= '0;
            r_mean_frames <= '0;
            r_mean_sum    <= '0;
            r_rate_frames <= '0;
            r_rate_sum    <= '0;
            r_mean_value  <= '0;
            r_rate_value  <= '0;
            r_elapsed     <= '0;
            r_mean_upd    <= 1'b0;
            r_rate_upd    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev     <= i_timestamp_ms;
                r_mean_upd <= 1'b0;
                r_rate_upd <= 1'b0;
            end
            if (i_cmd.acc) begin
                r_ticks       <= n_ticks;
                r_mean_frames <= n_mean_frames;
                r_mean_sum    <= n_mean_sum;
                r_rate_frames <= n_rate_frames;
                r_rate_sum    <= n_rate_sum;
            end
            if (i_cmd.write_back) begin
                if (i_cmd.sel_rate) begin
                    r_rate_value  <= quotient;
                    r_rate_frames <= '0;
                    r_rate_sum    <= '0;
                    r_rate_upd    <= 1'b1;
                end else begin
                    r_mean_value  <= quotient;
                    r_mean_frames <= '0;
                    r_mean_sum    <= '0;
                    r_mean_upd    <= 1'b1;
                end
            end
            if (i_cmd.add_elapsed) begin
                r_elapsed <= n_elapsed;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_delta <= n_delta;
        end
        if (i_cmd.mul) begin
            r_num <= prod;
            r_den <= i_cmd.sel_rate ? r_rate_sum : r_mean_frames;
        end
        if (i_cmd.div_load) begin
            r_rem <= 32'(num_adj[frm_pkg::NUM_BITS-1:32]);
            r_quo <= num_adj[31:0];
        end
        if (i_cmd.div_check) begin
            // high part already at or above the divisor: quotient exceeds 32 bits
            r_ovf <= (r_rem >= r_den);
            r_cnt <= frm_pkg::CNT_BITS'(frm_pkg::DIV_STEPS);
        end
        if (i_cmd.div_step) begin
            if (take) begin
                r_rem <= trial[31:0];
            end else begin
                r_rem <= shifted[31:0];
            end
            r_quo <= {r_quo[30:0], take};
            r_cnt <= r_cnt - frm_pkg::CNT_BITS'(1);
        end
        if (i_cmd.out_load) begin
            o_delta_ms             <= r_delta;
            o_frame_number         <= r_ticks;
            o_mean_frame_us        <= r_mean_value;
            o_frames_per_second_q8 <= r_rate_value;
            o_elapsed_us           <= r_elapsed;
            o_mean_updated         <= r_mean_upd;
            o_rate_updated         <= r_rate_upd;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- src/frame_rate_meter.sv -----
// Frame tick timing statistics.
// Input channel: one beat per frame tick (i_valid / o_stall) carrying the
// millisecond timestamp. Output channel: one beat per tick (o_valid / i_stall)
// with the delta, tick count, mean frame time, Q8 frame rate, elapsed time
// and the two update flags.
// Registers sit on an APB-style port: average window at 0x0, rate window
// at 0x4, 16 bits each, reset to 20 and 1000.
// A tick with no window update passes through the states ACC, TEST, ELAP
// and OUT. Each window update adds one pass through the shared multiplier
// and the 32-step restoring divider (MUL, ADJ, CHK, DIV, WB). One tick is
// worked at a time and o_stall is high until its result sits in the output
// register. A new tick is accepted while that result still waits on
// i_stall; its result is held back until the waiting beat is taken.
// Reset (synchronous, active low) clears the counters, windows, values,
// previous timestamp and o_valid, and loads the register defaults.
module frame_rate_meter #(
    parameter int STAMP_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [frm_pkg::DATA_BITS-1:0] pwdata,
    output logic [frm_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [31:0]                   i_timestamp_ms,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [31:0]                   o_delta_ms,
    output logic [31:0]                   o_frame_number,
    output logic [31:0]                   o_mean_frame_us,
    output logic [31:0]                   o_frames_per_second_q8,
    output logic [63:0]                   o_elapsed_us,
    output logic                          o_mean_updated,
    output logic                          o_rate_updated
);

    logic [frm_pkg::WIN_BITS-1:0] average_window_ms;
    logic [frm_pkg::WIN_BITS-1:0] rate_window_ms;
    frm_pkg::t_cmd                cmd;
    frm_pkg::t_sts                sts;

    frm_cfg u_cfg (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .o_average_window_ms (average_window_ms),
        .o_rate_window_ms    (rate_window_ms)
    );

    frm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    frm_dp #(
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .i_timestamp_ms         (i_timestamp_ms),
        .i_average_window_ms    (average_window_ms),
        .i_rate_window_ms       (rate_window_ms),
        .i_out_stall            (i_stall),
        .o_out_valid            (o_valid),
        .o_delta_ms             (o_delta_ms),
        .o_frame_number         (o_frame_number),
        .o_mean_frame_us        (o_mean_frame_us),
        .o_frames_per_second_q8 (o_frames_per_second_q8),
        .o_elapsed_us           (o_elapsed_us),
        .o_mean_updated         (o_mean_updated),
        .o_rate_updated         (o_rate_updated)
    );

endmodule

// ----- src/frm_chk.sv -----
module frm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_delta_ms,
    input logic [31:0] o_frame_number,
    input logic [31:0] o_mean_frame_us,
    input logic [63:0] o_elapsed_us
);

    // one tick in flight: the block closes its input right after a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_delta_ms)
                                  && $stable(o_frame_number)))
        else $error("stalled result dropped or changed");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_number != 32'd0))
        else $error("result with zero tick count");

    // elapsed already includes the mean added on this tick
    a_elapsed_covers_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elapsed_us >= {32'd0, o_mean_frame_us}))
        else $error("elapsed time below current mean");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind frame_rate_meter frm_chk u_frm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_delta_ms      (o_delta_ms),
    .o_frame_number  (o_frame_number),
    .o_mean_frame_us (o_mean_frame_us),
    .o_elapsed_us    (o_elapsed_us)
);
